/* rtl/core/atb_pkg.sv */
`timescale 1ns / 1ps

package atb_pkg;

	localparam int TIME_W = 40;
	localparam int TOD_W  = 17;
	localparam int LEFT_W = 18;
	localparam int CHAN_W = 4;

	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_STOP  = 2'd2;
	localparam logic [1:0] MODE_LOAD  = 2'd3;

	localparam logic [TIME_W-1:0] SECS_PER_HOUR = TIME_W'(3600);
	localparam logic [TIME_W-1:0] SECS_PER_DAY  = TIME_W'(24 * 3600);
	localparam logic [LEFT_W-1:0] LEFT_MAX      = LEFT_W'(2 * 24 * 3600 - 1);

	// one stored channel record
	typedef struct packed {
		logic              kind;
		logic              repeats;
		logic [TOD_W-1:0]  preset;
		logic [TIME_W-1:0] deadline;
	} entry_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_item;
		logic rd_en;
		logic finish;
	} ctrl_t;

endpackage

/* rtl/core/atb_ctrl.sv */
`timescale 1ns / 1ps

module atb_ctrl #(
	parameter int NUM_CHANNELS = 16,
	parameter int AW = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output atb_pkg::ctrl_t       cmd,
	output logic [AW-1:0]        rd_addr
);
	import atb_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_WALK   = 3'd1;
	localparam logic [2:0] ST_DRAIN1 = 3'd2;
	localparam logic [2:0] ST_DRAIN2 = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_CHANNELS - 1);

	logic [2:0]    state_q;
	logic [AW-1:0] cnt_q;
	logic          accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		cmd.load_item = accept;
		cmd.rd_en     = (state_q == ST_WALK);
		cmd.finish    = (state_q == ST_FINISH);
	end
	assign rd_addr = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (cnt_q == LAST_ADDR) begin
						state_q <= ST_DRAIN1;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				// wait for the last channel to clear both pipeline stages
				ST_DRAIN1: state_q <= ST_DRAIN2;
				ST_DRAIN2: state_q <= ST_FINISH;
				ST_FINISH: state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/atb_datapath.sv */
`timescale 1ns / 1ps

module atb_datapath #(
	parameter int NUM_CHANNELS = 16,
	parameter int AW = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  atb_pkg::ctrl_t               cmd,
	input  logic [AW-1:0]                rd_addr,
	input  logic [1:0]                   mode,
	input  logic [atb_pkg::CHAN_W-1:0]   channel,
	input  logic [atb_pkg::TIME_W-1:0]   now_secs,
	input  logic [atb_pkg::TOD_W-1:0]    time_of_day,
	input  logic                         alarm_kind,
	input  logic [atb_pkg::TOD_W-1:0]    set_value,
	input  logic                         repeat_flag,
	output logic                         result_valid,
	output logic                         fired,
	output logic [atb_pkg::CHAN_W-1:0]   fired_channel,
	output logic                         nearest_valid,
	output logic [atb_pkg::CHAN_W-1:0]   nearest_channel,
	output logic [atb_pkg::LEFT_W-1:0]   nearest_left,
	output logic                         last
);
	import atb_pkg::*;

	localparam int CMP_W = (AW > CHAN_W) ? AW : CHAN_W;

	// request registers
	logic [1:0]        mode_q;
	logic [CHAN_W-1:0] chan_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] midnight_q;
	logic [TOD_W-1:0]  tod_q;
	logic              kind_q;
	logic [TOD_W-1:0]  set_q;
	logic              rep_q;

	entry_t                  mem [NUM_CHANNELS];
	entry_t                  rdata_s1;
	logic                    v_s1;
	logic [AW-1:0]           addr_s1;
	logic [NUM_CHANNELS-1:0] armed_q;

	logic              v_s2;
	logic              armed_s2;
	logic [TIME_W-1:0] dl_s2;
	logic [AW-1:0]     addr_s2;

	logic              best_valid_q;
	logic [TIME_W-1:0] best_dl_q;
	logic [AW-1:0]     best_ch_q;

	logic              cur_armed;
	logic              match;
	logic              fire;
	logic [TIME_W-1:0] arm_base;
	logic [TIME_W-1:0] arm_day;
	logic [TIME_W-1:0] arm_end;
	logic              new_armed;
	logic [TIME_W-1:0] new_dl;
	logic              wen;
	entry_t            wentry;

	logic [TIME_W-1:0] diff;
	logic [LEFT_W-1:0] left_val;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			mode_q     <= mode;
			chan_q     <= channel;
			now_q      <= now_secs;
			midnight_q <= now_secs - TIME_W'(time_of_day);
			tod_q      <= time_of_day;
			kind_q     <= alarm_kind;
			set_q      <= set_value;
			rep_q      <= repeat_flag;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) rdata_s1 <= mem[rd_addr];
		if (wen) mem[addr_s1] <= wentry;
	end

	// evaluate one channel against the request
	always_comb begin
		cur_armed = armed_q[addr_s1];
		match     = (mode_q != MODE_TICK) && (CMP_W'(addr_s1) == CMP_W'(chan_q));
		fire      = (mode_q == MODE_TICK) && cur_armed && (rdata_s1.deadline <= now_q);
		arm_base  = rdata_s1.kind ? midnight_q : now_q;
		arm_day   = (rdata_s1.kind && (tod_q > rdata_s1.preset)) ? SECS_PER_DAY : '0;
		arm_end   = arm_base + TIME_W'(rdata_s1.preset) + arm_day;

		new_armed = cur_armed;
		new_dl    = rdata_s1.deadline;
		wen       = 1'b0;
		wentry    = rdata_s1;
		if (v_s1) begin
			if (fire) begin
				new_armed = rdata_s1.repeats;
				if (rdata_s1.repeats) begin
					new_dl = arm_end;
					wen    = 1'b1;
				end
			end else if (match) begin
				unique case (mode_q)
					MODE_START: begin
						new_armed = 1'b1;
						new_dl    = arm_end;
						wen       = 1'b1;
					end
					MODE_STOP: new_armed = 1'b0;
					MODE_LOAD: begin
						new_armed      = 1'b0;
						wen            = 1'b1;
						wentry.kind    = kind_q;
						wentry.repeats = rep_q;
						wentry.preset  = set_q;
					end
					default: new_armed = cur_armed;
				endcase
			end
		end
		wentry.deadline = (wen && mode_q != MODE_LOAD) ? new_dl : rdata_s1.deadline;
	end

	always_comb begin
		diff     = best_dl_q - now_q;
		left_val = '0;
		if (best_valid_q && (best_dl_q > now_q)) begin
			left_val = (diff > TIME_W'(LEFT_MAX)) ? LEFT_MAX : diff[LEFT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			best_valid_q <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
			if (v_s1) armed_q[addr_s1] <= new_armed;

			// fold the settled channel into the nearest deadline
			if (cmd.load_item) begin
				best_valid_q <= 1'b0;
			end else if (v_s2 && armed_s2 && (!best_valid_q || dl_s2 < best_dl_q)) begin
				best_valid_q <= 1'b1;
			end

			result_valid <= (v_s1 && fire) || cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1  <= rd_addr;
		armed_s2 <= new_armed;
		dl_s2    <= new_dl;
		addr_s2  <= addr_s1;
		if (!cmd.load_item && v_s2 && armed_s2 && (!best_valid_q || dl_s2 < best_dl_q)) begin
			best_dl_q <= dl_s2;
			best_ch_q <= addr_s2;
		end
		if (cmd.finish) begin
			fired           <= 1'b0;
			fired_channel   <= '0;
			nearest_valid   <= best_valid_q;
			nearest_channel <= best_valid_q ? CHAN_W'(best_ch_q) : '0;
			nearest_left    <= left_val;
			last            <= 1'b1;
		end else begin
			fired           <= 1'b1;
			fired_channel   <= CHAN_W'(addr_s1);
			nearest_valid   <= 1'b0;
			nearest_channel <= '0;
			nearest_left    <= '0;
			last            <= 1'b0;
		end
	end

endmodule

/* rtl/core/alarm_timer_bank_top.sv */
`timescale 1ns / 1ps
// Bank of NUM_CHANNELS countdown timers and time-of-day alarms.
// Request channel: drive mode, channel, now_secs, time_of_day and the load
// fields, raise start; the request is taken at a clock edge with start high
// and busy low. Modes: tick, start channel, stop channel, load channel.
// Each request walks every channel once through a one-read one-write record
// memory, one channel per cycle, in a three-stage read / evaluate / fold pipeline.
// Result channel: result_valid marks each result for exactly one cycle.
// A tick gives one fired result per expired channel, lowest index first,
// then every request ends with a result carrying last, nearest_valid,
// nearest_channel and nearest_left (saturated seconds to the nearest deadline).
// The final result is registered from the finish state, which follows the walk
// and the drain states; busy stays high from the request until that result
// appears, so a new request is taken only once the last one is through.
// The receiver cannot stall; results are never held back.
// Reset disarms all channels and returns the controller to idle. Channel
// records hold no reset value; load a channel before starting it.
module alarm_timer_bank_top #(
	parameter int NUM_CHANNELS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   mode,
	input  logic [atb_pkg::CHAN_W-1:0]   channel,
	input  logic [atb_pkg::TIME_W-1:0]   now_secs,
	input  logic [atb_pkg::TOD_W-1:0]    time_of_day,
	input  logic                         alarm_kind,
	input  logic [atb_pkg::TOD_W-1:0]    set_value,
	input  logic                         repeat_flag,
	output logic                         result_valid,
	output logic                         fired,
	output logic [atb_pkg::CHAN_W-1:0]   fired_channel,
	output logic                         nearest_valid,
	output logic [atb_pkg::CHAN_W-1:0]   nearest_channel,
	output logic [atb_pkg::LEFT_W-1:0]   nearest_left,
	output logic                         last
);
	import atb_pkg::*;

	localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	ctrl_t         cmd;
	logic [AW-1:0] rd_addr;

	atb_ctrl #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.rd_addr(rd_addr)
	);

	atb_datapath #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.AW(AW)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.rd_addr(rd_addr),
		.mode(mode),
		.channel(channel),
		.now_secs(now_secs),
		.time_of_day(time_of_day),
		.alarm_kind(alarm_kind),
		.set_value(set_value),
		.repeat_flag(repeat_flag),
		.result_valid(result_valid),
		.fired(fired),
		.fired_channel(fired_channel),
		.nearest_valid(nearest_valid),
		.nearest_channel(nearest_channel),
		.nearest_left(nearest_left),
		.last(last)
	);

endmodule
